>>> src/tsp_pkg.sv
package tsp_pkg;

  localparam int TS_W     = 32;
  localparam int RANK_W   = 16;
  localparam int SLOT_W   = 3;
  localparam int SLOT_CNT = 8;

  localparam logic [TS_W-1:0] BASE_TIME_RESET = 32'd1389040865;
  localparam logic [1:0]      BASE_TIME_ADDR  = 2'd0;

  typedef logic [SLOT_CNT-1:0][SLOT_W-1:0] slot_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0]   rank;
    logic [RANK_W-1:0]   rem;
    logic [SLOT_CNT-1:0] used;
    slot_vec_t           slots;
  } perm_word_t;

  function automatic int fact(input int n);
    int f;
    f = 1;
    for (int k = 2; k <= n; k++) begin
      f = f * k;
    end
    return f;
  endfunction

endpackage

>>> src/timestamp_to_permutation_top.sv
// Throughput is one word per cycle while out_ready is held high: four stages reduce
// the timestamp by reciprocal multiplication, then one stage per permutation position
// extracts a digit.
// Stalls back up through per-stage valid bits without losing or repeating a word.
// Reset is synchronous and active low; it empties the pipeline and restores base_time.
module timestamp_to_permutation_top #(
  parameter int NUM_ITEMS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tsp_pkg::TS_W-1:0]           in_timestamp,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tsp_pkg::RANK_W-1:0]         out_rank,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot0,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot1,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot2,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot3,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot4,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot5,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot6,
  output logic [tsp_pkg::SLOT_W-1:0]         out_slot7
);

  logic [tsp_pkg::TS_W-1:0]   base_time_r;
  logic                       red_valid;
  logic                       red_ready;
  logic [tsp_pkg::RANK_W-1:0] red_rank;

  logic                       dig_valid [NUM_ITEMS+1];
  logic                       dig_ready [NUM_ITEMS+1];
  tsp_pkg::perm_word_t        dig_word  [NUM_ITEMS+1];

  assign pready = 1'b1;
  assign prdata = base_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_time_r <= tsp_pkg::BASE_TIME_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == tsp_pkg::BASE_TIME_ADDR)) begin
      base_time_r <= pwdata;
    end
  end

  tsp_reduce #(
    .NUM_ITEMS (NUM_ITEMS)
  ) u_reduce (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_timestamp (in_timestamp),
    .base_time    (base_time_r),
    .out_valid    (red_valid),
    .out_ready    (red_ready),
    .out_rank     (red_rank)
  );

  always_comb begin
    dig_word[0]       = '0;
    dig_word[0].rank  = red_rank;
    dig_word[0].rem   = red_rank;
  end
  assign dig_valid[0] = red_valid;
  assign red_ready    = dig_ready[0];

  for (genvar p = 0; p < NUM_ITEMS; p++) begin : g_digit
    tsp_digit #(
      .NUM_ITEMS (NUM_ITEMS),
      .POS       (p)
    ) u_digit (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dig_valid[p]),
      .in_ready  (dig_ready[p]),
      .in_word   (dig_word[p]),
      .out_valid (dig_valid[p+1]),
      .out_ready (dig_ready[p+1]),
      .out_word  (dig_word[p+1])
    );
  end

  assign dig_ready[NUM_ITEMS] = out_ready;
  assign out_valid = dig_valid[NUM_ITEMS];
  assign out_rank  = dig_word[NUM_ITEMS].rank;
  assign out_slot0 = dig_word[NUM_ITEMS].slots[0];
  assign out_slot1 = dig_word[NUM_ITEMS].slots[1];
  assign out_slot2 = dig_word[NUM_ITEMS].slots[2];
  assign out_slot3 = dig_word[NUM_ITEMS].slots[3];
  assign out_slot4 = dig_word[NUM_ITEMS].slots[4];
  assign out_slot5 = dig_word[NUM_ITEMS].slots[5];
  assign out_slot6 = dig_word[NUM_ITEMS].slots[6];
  assign out_slot7 = dig_word[NUM_ITEMS].slots[7];

endmodule

>>> src/tsp_reduce.sv
module tsp_reduce #(
  parameter int NUM_ITEMS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tsp_pkg::TS_W-1:0]    in_timestamp,
  input  logic [tsp_pkg::TS_W-1:0]    base_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tsp_pkg::RANK_W-1:0]  out_rank
);

  localparam int FACT      = tsp_pkg::fact(NUM_ITEMS);
  localparam int SHIFT     = tsp_pkg::TS_W + $clog2(FACT);
  localparam int RECIP_W   = tsp_pkg::TS_W + 1;
  localparam int PROD_W    = tsp_pkg::TS_W + RECIP_W;
  localparam int REM_W     = tsp_pkg::RANK_W + 1;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(FACT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [3:0] v_r;
  logic [3:0] rdy;

  logic [tsp_pkg::TS_W-1:0]   diff1_r, diff2_r, diff3_r;
  logic [tsp_pkg::TS_W-1:0]   quo_r;
  logic [tsp_pkg::TS_W-1:0]   qd_r;
  logic [tsp_pkg::RANK_W-1:0] rank_r;

  logic [PROD_W-1:0]          prod;
  logic [tsp_pkg::TS_W-1:0]   diff_low;
  logic [REM_W-1:0]           rem17;

  assign rdy[3]   = !v_r[3] || out_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  assign prod     = PROD_W'(diff1_r) * PROD_W'(RECIP);
  assign diff_low = diff3_r - qd_r;
  assign rem17    = diff_low[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      diff1_r <= in_timestamp - base_time;
    end
    if (rdy[1]) begin
      diff2_r <= diff1_r;
      quo_r   <= tsp_pkg::TS_W'(prod >> SHIFT);
    end
    if (rdy[2]) begin
      diff3_r <= diff2_r;
      qd_r    <= quo_r * tsp_pkg::TS_W'(FACT);
    end
    if (rdy[3]) begin
      if (rem17 >= REM_W'(FACT)) begin
        rank_r <= tsp_pkg::RANK_W'(rem17 - REM_W'(FACT));
      end else begin
        rank_r <= tsp_pkg::RANK_W'(rem17);
      end
    end
  end

  assign out_valid = v_r[3];
  assign out_rank  = rank_r;

endmodule

>>> src/tsp_digit.sv
module tsp_digit #(
  parameter int NUM_ITEMS = 8,
  parameter int POS       = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsp_pkg::perm_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tsp_pkg::perm_word_t out_word
);

  localparam int F     = tsp_pkg::fact(NUM_ITEMS - 1 - POS);
  localparam int CMP_W = tsp_pkg::RANK_W + 1;
  localparam int CNT_W = $clog2(tsp_pkg::SLOT_CNT) + 1;

  logic                        v_r;
  tsp_pkg::perm_word_t         word_r;
  tsp_pkg::perm_word_t         word_nxt;
  logic [tsp_pkg::SLOT_CNT-1:0] ge;
  logic [tsp_pkg::RANK_W-1:0]  sub;
  logic [tsp_pkg::SLOT_W-1:0]  digit;
  logic [tsp_pkg::SLOT_W-1:0]  pick;
  logic [CNT_W-1:0]            cnt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    ge  = '0;
    sub = '0;
    for (int k = 1; k < tsp_pkg::SLOT_CNT; k++) begin
      ge[k] = {1'b0, in_word.rem} >= CMP_W'(k * F);
      if (ge[k]) begin
        sub = tsp_pkg::RANK_W'(k * F);
      end
    end
    digit = tsp_pkg::SLOT_W'($countones(ge));
  end

  always_comb begin
    cnt  = '0;
    pick = '0;
    for (int e = 0; e < tsp_pkg::SLOT_CNT; e++) begin
      if (!in_word.used[e]) begin
        if (cnt == {1'b0, digit}) begin
          pick = tsp_pkg::SLOT_W'(e);
        end
        cnt = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    word_nxt             = in_word;
    word_nxt.rem         = in_word.rem - sub;
    word_nxt.used[pick]  = 1'b1;
    word_nxt.slots[POS]  = pick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

>>> test/tb_timestamp_to_permutation_top.sv
module tb_timestamp_to_permutation_top;

  localparam int NUM_ITEMS = 8;
  localparam int PIPE_DEPTH = 4 + NUM_ITEMS;
  localparam int MAX_WAIT = 17;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANK_SPAN = 40320;

  typedef struct packed {
    logic [tsp_pkg::RANK_W-1:0] rank;
    tsp_pkg::slot_vec_t         slots;
  } perm_result_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [1:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [tsp_pkg::TS_W-1:0]  in_timestamp = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [tsp_pkg::RANK_W-1:0] out_rank;
  logic [tsp_pkg::SLOT_W-1:0] out_slot0, out_slot1, out_slot2, out_slot3;
  logic [tsp_pkg::SLOT_W-1:0] out_slot4, out_slot5, out_slot6, out_slot7;

  logic [tsp_pkg::TS_W-1:0] base_time_copy = tsp_pkg::BASE_TIME_RESET;
  perm_result_t    pending_perms[$];
  int              mismatches = 0;
  int              cycle_count = 0;
  int              send_left = 0;
  int              send_mode = 0;
  int              recv_left = 0;
  int              recv_mode = 0;

  timestamp_to_permutation_top #(
    .NUM_ITEMS(NUM_ITEMS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rank(out_rank),
    .out_slot0(out_slot0),
    .out_slot1(out_slot1),
    .out_slot2(out_slot2),
    .out_slot3(out_slot3),
    .out_slot4(out_slot4),
    .out_slot5(out_slot5),
    .out_slot6(out_slot6),
    .out_slot7(out_slot7)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The rank is split into factorial digits; each digit picks the n-th smallest
  // element that no earlier position has taken.
  function automatic perm_result_t unrank_timestamp(input logic [tsp_pkg::TS_W-1:0] ts,
                                                    input logic [tsp_pkg::TS_W-1:0] base);
    perm_result_t     r;
    logic [tsp_pkg::TS_W-1:0]  diff;
    int unsigned      total;
    int unsigned      remain;
    int unsigned      weight;
    int unsigned      digit;
    bit               taken[tsp_pkg::SLOT_CNT];
    bit               placed;
    total = 1;
    for (int k = 2; k <= NUM_ITEMS; k++) total = total * k;
    diff = ts - base;
    remain = diff % total;
    r.rank = remain[tsp_pkg::RANK_W-1:0];
    r.slots = '0;
    foreach (taken[e]) taken[e] = 1'b0;
    for (int pos = 0; pos < NUM_ITEMS; pos++) begin
      weight = 1;
      for (int k = 2; k <= NUM_ITEMS - 1 - pos; k++) weight = weight * k;
      digit = remain / weight;
      remain = remain % weight;
      placed = 1'b0;
      for (int e = 0; e < tsp_pkg::SLOT_CNT; e++) begin
        if (!taken[e] && !placed) begin
          if (digit == 0) begin
            taken[e] = 1'b1;
            r.slots[pos] = e[tsp_pkg::SLOT_W-1:0];
            placed = 1'b1;
          end else begin
            digit--;
          end
        end
      end
    end
    return r;
  endfunction

  // Waits come in stretches: none at all, short ones, or the full range.
  function automatic int draw_wait(ref int left, ref int mode);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      mode = $urandom_range(0, 2);
    end
    left--;
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  task automatic write_base_time(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsp_pkg::BASE_TIME_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    base_time_copy = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Valid stays high across back-to-back words, so it is only lowered before a gap or when the pipeline drains.
  task automatic send_timestamp(input logic [tsp_pkg::TS_W-1:0] ts);
    int gap;
    gap = draw_wait(send_left, send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_perms.push_back(unrank_timestamp(ts, base_time_copy));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_perms.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic logic [tsp_pkg::TS_W-1:0] pick_timestamp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return base_time_copy + $urandom_range(0, 3 * RANK_SPAN);
      6: return base_time_copy - $urandom_range(1, RANK_SPAN);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_base();
    send_timestamp(tsp_pkg::BASE_TIME_RESET);
    send_timestamp(tsp_pkg::BASE_TIME_RESET + 1);
    send_timestamp(tsp_pkg::BASE_TIME_RESET + 5039);
    send_timestamp(tsp_pkg::BASE_TIME_RESET + 5040);
    send_timestamp(tsp_pkg::BASE_TIME_RESET + RANK_SPAN - 1);
    send_timestamp(tsp_pkg::BASE_TIME_RESET + RANK_SPAN);
    send_timestamp(tsp_pkg::BASE_TIME_RESET - 1);
    send_timestamp(32'h0000_0000);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(32'hAAAA_AAAA);
    send_timestamp(32'h5555_5555);
    drain_pipeline();
  endtask

  task automatic test_base_extremes();
    write_base_time(32'h0000_0000);
    send_timestamp(32'h0000_0000);
    send_timestamp(RANK_SPAN - 1);
    send_timestamp(RANK_SPAN);
    send_timestamp(32'hFFFF_FFFF);
    drain_pipeline();
    write_base_time(32'hFFFF_FFFF);
    send_timestamp(32'h0000_0000);
    send_timestamp(32'hFFFF_FFFE);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(RANK_SPAN - 2);
    drain_pipeline();
  endtask

  task automatic test_random_bases();
    logic [31:0] bases[6];
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = $urandom;
    bases[3] = tsp_pkg::BASE_TIME_RESET;
    bases[4] = $urandom;
    bases[5] = 32'hFFFF_FFFF - $urandom_range(0, RANK_SPAN);
    foreach (bases[p]) begin
      write_base_time(bases[p]);
      repeat (322) send_timestamp(pick_timestamp());
      drain_pipeline();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_base();
    test_base_extremes();
    test_random_bases();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_left, recv_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    perm_result_t       want;
    tsp_pkg::slot_vec_t got_slots;
    if (rst_n && out_valid && out_ready) begin
      got_slots = {out_slot7, out_slot6, out_slot5, out_slot4,
                   out_slot3, out_slot2, out_slot1, out_slot0};
      if (pending_perms.size() == 0) begin
        $error("result word with no pending expectation: rank %0d", out_rank);
        mismatches++;
      end else begin
        want = pending_perms.pop_front();
        if (out_rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_rank);
          mismatches++;
        end
        for (int s = 0; s < tsp_pkg::SLOT_CNT; s++) begin
          if (got_slots[s] !== want.slots[s]) begin
            $error("slot%0d: expected %0d, got %0d", s, want.slots[s], got_slots[s]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
